### rtl/lgt_pkg.sv
`default_nettype none
package lgt_pkg;

  // grid geometry, fixed by the index field widths
  localparam int unsigned ROW_W    = 6;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned MAX_ROWS = 1 << ROW_W;
  localparam int unsigned MAX_COLS = 1 << COL_W;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 3;

  // register indexes (paddr[2])
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STEP  = 2'd2
  } lgt_action_e;

  typedef enum logic [1:0] {
    RD_ITEM = 2'd0,
    RD_UP   = 2'd1,
    RD_MID  = 2'd2,
    RD_DN   = 2'd3
  } lgt_rd_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_ITEM_RD,
    ST_ITEM_USE,
    ST_RD_UP,
    ST_RD_MID,
    ST_RD_DN,
    ST_LAT_DN,
    ST_CALC,
    ST_CP_RD,
    ST_CP_WR,
    ST_DONE
  } lgt_state_e;

  typedef struct packed {
    logic        latch_item;
    logic        mod_init;
    logic        mod_step;
    logic        cur_rd;
    lgt_rd_sel_e rd_sel;
    logic        lat_up;
    logic        lat_mid;
    logic        lat_dn;
    logic        cell_wr;
    logic        next_wr;
    logic        row_clr;
    logic        alive_clr;
    logic        row_inc;
    logic        nxt_rd;
    logic        copy_wr;
    logic        out_load;
  } lgt_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       mod_last;
    logic       row_last;
  } lgt_sts_t;

endpackage
`default_nettype wire

### rtl/lgt_ctrl.sv
`default_nettype none
module lgt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        in_action_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire lgt_pkg::lgt_sts_t sts_i,
  output lgt_pkg::lgt_cmd_t      cmd_o
);
  import lgt_pkg::*;

  lgt_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // state and result valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_ITEM;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          cmd_o.mod_init   = 1'b1;
          case (in_action_i) inside
            ACT_WRITE, ACT_READ: state_d = ST_MOD;
            ACT_STEP: begin
              cmd_o.row_clr   = 1'b1;
              cmd_o.alive_clr = 1'b1;
              state_d         = ST_RD_UP;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) state_d = ST_ITEM_RD;
      end
      ST_ITEM_RD: begin
        cmd_o.cur_rd = 1'b1;
        cmd_o.rd_sel = RD_ITEM;
        state_d      = ST_ITEM_USE;
      end
      ST_ITEM_USE: begin
        cmd_o.cell_wr = (sts_i.act == ACT_WRITE);
        state_d       = ST_DONE;
      end
      ST_RD_UP: begin
        cmd_o.cur_rd = 1'b1;
        cmd_o.rd_sel = RD_UP;
        state_d      = ST_RD_MID;
      end
      ST_RD_MID: begin
        cmd_o.cur_rd = 1'b1;
        cmd_o.rd_sel = RD_MID;
        cmd_o.lat_up = 1'b1;
        state_d      = ST_RD_DN;
      end
      ST_RD_DN: begin
        cmd_o.cur_rd  = 1'b1;
        cmd_o.rd_sel  = RD_DN;
        cmd_o.lat_mid = 1'b1;
        state_d       = ST_LAT_DN;
      end
      ST_LAT_DN: begin
        cmd_o.lat_dn = 1'b1;
        state_d      = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.next_wr = 1'b1;
        if (sts_i.row_last) begin
          cmd_o.row_clr = 1'b1;
          state_d       = ST_CP_RD;
        end else begin
          cmd_o.row_inc = 1'b1;
          state_d       = ST_RD_UP;
        end
      end
      ST_CP_RD: begin
        cmd_o.nxt_rd = 1'b1;
        state_d      = ST_CP_WR;
      end
      ST_CP_WR: begin
        cmd_o.copy_wr = 1'b1;
        if (sts_i.row_last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.row_inc = 1'b1;
          state_d       = ST_CP_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result beat held until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

endmodule
`default_nettype wire

### rtl/lgt_dp.sv
`default_nettype none
module lgt_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [lgt_pkg::SIZE_W-1:0] rows_cfg_i,
  input  wire logic [lgt_pkg::SIZE_W-1:0] cols_cfg_i,
  input  wire logic [1:0]                 action_i,
  input  wire logic [lgt_pkg::ROW_W-1:0]  row_i,
  input  wire logic [lgt_pkg::COL_W-1:0]  col_i,
  input  wire logic                       write_value_i,
  input  wire lgt_pkg::lgt_cmd_t          cmd_i,
  output lgt_pkg::lgt_sts_t               sts_o,
  output logic                            read_value_o,
  output logic                            any_alive_o
);
  import lgt_pkg::*;

  localparam int unsigned MODW = SIZE_W + ROW_W - 1;

  logic [SIZE_W-1:0]   nr, nc;
  logic [ROW_W-1:0]    nr_m1;
  logic [COL_W-1:0]    nc_m1;

  logic [1:0]          act_q;
  logic                wv_q;
  logic [ROW_W-1:0]    rrem_q;
  logic [COL_W-1:0]    crem_q;
  logic [2:0]          mod_k_q;
  logic [ROW_W-1:0]    row_q;
  logic                alive_q;

  logic [MAX_COLS-1:0] cur_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] nxt_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_vld_q;
  logic [MAX_COLS-1:0] cur_rd_q, nxt_rd_q;
  logic                cur_vld_q;
  logic [MAX_COLS-1:0] cur_data;
  logic [ROW_W-1:0]    rd_addr;

  logic [MAX_COLS-1:0] win_up_q, win_mid_q, win_dn_q;
  logic [MAX_COLS-1:0] new_row, live_mask, merged;
  logic [ROW_W-1:0]    wr_addr;
  logic [MAX_COLS-1:0] wr_data;

  logic [MODW-1:0]     rdiv, cdiv;

  // sizes in use, zero treated as one, saturated at the maximum
  always_comb begin
    nr = rows_cfg_i;
    if (rows_cfg_i == '0) nr = SIZE_W'(1);
    else if (rows_cfg_i > SIZE_W'(MAX_ROWS)) nr = SIZE_W'(MAX_ROWS);
    nc = cols_cfg_i;
    if (cols_cfg_i == '0) nc = SIZE_W'(1);
    else if (cols_cfg_i > SIZE_W'(MAX_COLS)) nc = SIZE_W'(MAX_COLS);
    nr_m1 = ROW_W'(nr - SIZE_W'(1));
    nc_m1 = COL_W'(nc - SIZE_W'(1));
  end

  // item fields and restoring remainder, one shifted divisor per cycle
  assign rdiv = MODW'(nr) << mod_k_q;
  assign cdiv = MODW'(nc) << mod_k_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      act_q <= action_i;
      wv_q  <= write_value_i;
    end
    if (cmd_i.mod_init) begin
      rrem_q  <= row_i;
      crem_q  <= col_i;
      mod_k_q <= 3'(ROW_W - 1);
    end else if (cmd_i.mod_step) begin
      if (MODW'(rrem_q) >= rdiv) rrem_q <= ROW_W'(MODW'(rrem_q) - rdiv);
      if (MODW'(crem_q) >= cdiv) crem_q <= COL_W'(MODW'(crem_q) - cdiv);
      mod_k_q <= mod_k_q - 3'd1;
    end
  end

  // row counter and live flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      alive_q <= 1'b0;
    end else begin
      if (cmd_i.row_clr) row_q <= '0;
      else if (cmd_i.row_inc) row_q <= row_q + ROW_W'(1);
      if (cmd_i.alive_clr) alive_q <= 1'b0;
      else if (cmd_i.next_wr) alive_q <= alive_q | (|(new_row & live_mask));
    end
  end

  // read address of the current grid
  always_comb begin
    case (cmd_i.rd_sel)
      RD_UP:   rd_addr = (row_q == '0) ? nr_m1 : row_q - ROW_W'(1);
      RD_MID:  rd_addr = row_q;
      RD_DN:   rd_addr = (row_q == nr_m1) ? '0 : row_q + ROW_W'(1);
      default: rd_addr = rrem_q;
    endcase
  end

  // row valid flags: a row never written reads as all dead
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      cur_vld_q <= 1'b0;
    end else begin
      if (cmd_i.cur_rd) cur_vld_q <= row_vld_q[rd_addr];
      if (cmd_i.cell_wr || cmd_i.copy_wr) row_vld_q[wr_addr] <= 1'b1;
    end
  end

  // current grid, one row per entry
  assign wr_addr = cmd_i.cell_wr ? rrem_q : row_q;
  assign wr_data = cmd_i.cell_wr ? merged : nxt_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_rd) cur_rd_q <= cur_mem[rd_addr];
    if (cmd_i.cell_wr || cmd_i.copy_wr) cur_mem[wr_addr] <= wr_data;
  end

  assign cur_data = cur_vld_q ? cur_rd_q : '0;

  always_comb begin
    merged         = cur_data;
    merged[crem_q] = wv_q;
  end

  // next grid
  always_ff @(posedge clk_i) begin
    if (cmd_i.nxt_rd) nxt_rd_q <= nxt_mem[row_q];
    if (cmd_i.next_wr) nxt_mem[row_q] <= new_row;
  end

  // three-row window
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_up)  win_up_q  <= cur_data;
    if (cmd_i.lat_mid) win_mid_q <= cur_data;
    if (cmd_i.lat_dn)  win_dn_q  <= cur_data;
  end

  // one new row: each column counts its eight wrapped neighbours
  always_comb begin
    logic [MAX_COLS-1:0] up_l, up_r, mid_l, mid_r, dn_l, dn_r;
    logic [3:0]          cnt;
    up_l  = {win_up_q[MAX_COLS-2:0],  win_up_q[nc_m1]};
    mid_l = {win_mid_q[MAX_COLS-2:0], win_mid_q[nc_m1]};
    dn_l  = {win_dn_q[MAX_COLS-2:0],  win_dn_q[nc_m1]};
    up_r  = {1'b0, win_up_q[MAX_COLS-1:1]};
    mid_r = {1'b0, win_mid_q[MAX_COLS-1:1]};
    dn_r  = {1'b0, win_dn_q[MAX_COLS-1:1]};
    up_r[nc_m1]  = win_up_q[0];
    mid_r[nc_m1] = win_mid_q[0];
    dn_r[nc_m1]  = win_dn_q[0];
    for (int c = 0; c < MAX_COLS; c++) begin
      cnt = 4'(up_l[c]) + 4'(win_up_q[c]) + 4'(up_r[c])
          + 4'(mid_l[c]) + 4'(mid_r[c])
          + 4'(dn_l[c]) + 4'(win_dn_q[c]) + 4'(dn_r[c]);
      live_mask[c] = (COL_W'(c) <= nc_m1);
      if (live_mask[c]) begin
        new_row[c] = (cnt == 4'd3) || ((cnt == 4'd2) && win_mid_q[c]);
      end else begin
        new_row[c] = win_mid_q[c];
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      read_value_o <= (act_q == ACT_READ) & cur_data[crem_q];
      any_alive_o  <= (act_q == ACT_STEP) & alive_q;
    end
  end

  assign sts_o.act      = act_q;
  assign sts_o.mod_last = (mod_k_q == 3'd0);
  assign sts_o.row_last = (row_q == nr_m1);

endmodule
`default_nettype wire

### rtl/life_generation_torus_unit.sv
// Game of life on a toroidal grid of up to 64 by 64 cells.
// Input channel (in_valid_i / in_stall_o) takes one beat per item: action_i
// writes one cell, reads one cell or advances one generation. The output
// channel (out_valid_o / out_stall_i) returns one beat per item, read_value_o
// for a read, any_alive_o after a step, zero otherwise.
// The grid is a row-wide memory; a step reads three rows per grid row and
// writes the new row into a second memory, then copies it back a row at a
// time. A write or read runs the remainder unit, a row access and the
// result; an unused action gives only the result; a step computes every
// row, copies every row back and then gives the result.
// One item is worked at a time; the next beat is taken once the result sits
// in the output register, so a stalled receiver holds one result and blocks
// only the item after next.
// Reset clears every row at once through per-row valid flags and sets both
// sizes to 64. The user must write the sizes over the APB port only while
// the unit is idle; the unit itself does not enforce it.
`default_nettype none
module life_generation_torus_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  action_i,
  input  wire logic [lgt_pkg::ROW_W-1:0]   row_i,
  input  wire logic [lgt_pkg::COL_W-1:0]   col_i,
  input  wire logic                        write_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             read_value_o,
  output logic                             any_alive_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lgt_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lgt_pkg::DATA_W-1:0]  pwdata,
  output logic [lgt_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import lgt_pkg::*;

  logic [SIZE_W-1:0] rows_q, cols_q;
  lgt_cmd_t          cmd;
  lgt_sts_t          sts;

  // size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= SIZE_W'(MAX_ROWS);
      cols_q <= SIZE_W'(MAX_COLS);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_ROWS: rows_q <= pwdata[SIZE_W-1:0];
        REG_COLS: cols_q <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_COLS) ? DATA_W'(cols_q) : DATA_W'(rows_q);

  lgt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (action_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lgt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rows_cfg_i    (rows_q),
    .cols_cfg_i    (cols_q),
    .action_i      (action_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .write_value_i (write_value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .read_value_o  (read_value_o),
    .any_alive_o   (any_alive_o)
  );

endmodule
`default_nettype wire
